/* rtl/wwps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wwps_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAT_BYTES   = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int LEN_FIELD_W = 6;
    localparam int OFS_W       = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_DIGIT_0  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIGIT_9  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UNDERSCR = 8'h5F;
    localparam logic [BYTE_W-1:0] CASE_DELTA  = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_0,
        REG_PATTERN_1,
        REG_PATTERN_2,
        REG_PATTERN_3,
        REG_PATTERN_LENGTH,
        REG_CASE_SENSITIVE,
        REG_WHOLE_WORD
    } cfg_reg_t;

    typedef struct packed {
        logic case_sensitive;
        logic whole_word;
    } match_mode_t;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic case_sensitive);
        if (!case_sensitive && b >= CH_UPPER_A && b <= CH_UPPER_Z)
            return b + CASE_DELTA;
        return b;
    endfunction

    function automatic logic is_word_byte(input logic [BYTE_W-1:0] b);
        return (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
               (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
               (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) ||
               (b == CH_UNDERSCR);
    endfunction

endpackage

`default_nettype wire

/* rtl/wwps_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module wwps_cfg #(
    parameter int MAX_PATTERN = 32,
    localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [wwps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wwps_pkg::CFG_W-1:0]     cfg_data,
    output wwps_pkg::match_mode_t               mode,
    output logic [LEN_W-1:0]                    pattern_len,
    output logic [wwps_pkg::BYTE_W-1:0]         pattern_aligned [MAX_PATTERN],
    output logic [MAX_PATTERN-1:0]              pattern_mask
);
    import wwps_pkg::*;

    localparam int CLW = ((LEN_W > LEN_FIELD_W) ? LEN_W : LEN_FIELD_W) + 1;

    logic [PAT_BYTES*BYTE_W-1:0] pattern_reg;
    logic [LEN_FIELD_W-1:0]      length_reg;
    logic                        case_sensitive_reg;
    logic                        whole_word_reg;

    logic [BYTE_W-1:0]      pat_ext [MAX_PATTERN];
    logic [CLW-1:0]         len_raw;
    logic [CLW-1:0]         len_clamped;
    logic [BYTE_W-1:0]      aligned_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] mask_next;

    logic [LEN_W-1:0]       len_reg;
    logic [BYTE_W-1:0]      aligned_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg        <= '0;
            length_reg         <= LEN_FIELD_W'(1);
            case_sensitive_reg <= 1'b0;
            whole_word_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_0:      pattern_reg[0*CFG_W +: CFG_W] <= cfg_data;
                REG_PATTERN_1:      pattern_reg[1*CFG_W +: CFG_W] <= cfg_data;
                REG_PATTERN_2:      pattern_reg[2*CFG_W +: CFG_W] <= cfg_data;
                REG_PATTERN_3:      pattern_reg[3*CFG_W +: CFG_W] <= cfg_data;
                REG_PATTERN_LENGTH: length_reg <= cfg_data[LEN_FIELD_W-1:0];
                REG_CASE_SENSITIVE: case_sensitive_reg <= cfg_data[0];
                REG_WHOLE_WORD:     whole_word_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // pattern bytes past the stored words read as zero
    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_pat
        if (g < PAT_BYTES)
        begin : g_stored
            assign pat_ext[g] = pattern_reg[g*BYTE_W +: BYTE_W];
        end
        else
        begin : g_zero
            assign pat_ext[g] = '0;
        end
    end

    always_comb
    begin
        len_raw = CLW'(length_reg);
        if (len_raw == '0)
            len_clamped = CLW'(1);
        else if (len_raw > CLW'(MAX_PATTERN))
            len_clamped = CLW'(MAX_PATTERN);
        else
            len_clamped = len_raw;
    end

    // slot i holds pattern byte len-1-i, so slot 0 lines up with the newest text byte
    always_comb
    begin
        logic [BYTE_W-1:0] sel;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            sel = '0;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (CLW'(i + j + 1) == len_clamped)
                    sel = pat_ext[j];
            end
            aligned_next[i] = fold_byte(sel, case_sensitive_reg);
            mask_next[i]    = CLW'(i) < len_clamped;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= LEN_W'(len_clamped);
        aligned_reg <= aligned_next;
        mask_reg    <= mask_next;
    end

    assign mode.case_sensitive = case_sensitive_reg;
    assign mode.whole_word     = whole_word_reg;
    assign pattern_len         = len_reg;
    assign pattern_aligned     = aligned_reg;
    assign pattern_mask        = mask_reg;

endmodule

`default_nettype wire

/* rtl/wwps_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module wwps_engine #(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_TEXT    = 65536,
    localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [wwps_pkg::BYTE_W-1:0] s_byte,
    input  wire logic                        s_last,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_found,
    output logic [wwps_pkg::OFS_W-1:0]       m_offset,
    input  wire wwps_pkg::match_mode_t       mode,
    input  wire logic [LEN_W-1:0]            pattern_len,
    input  wire logic [wwps_pkg::BYTE_W-1:0] pattern_aligned [MAX_PATTERN],
    input  wire logic [MAX_PATTERN-1:0]      pattern_mask
);
    import wwps_pkg::*;

    localparam int DEPTH = MAX_PATTERN + 2;
    localparam int CNT_W = $clog2(MAX_TEXT + 2);
    localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int EXT_W = (CNT_W > OFS_W) ? CNT_W : OFS_W;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic [BYTE_W-1:0] win_reg [DEPTH];
    logic [CNT_W-1:0]  seen_reg;
    logic              reported_reg;

    logic              out_valid_reg;
    logic              out_found_reg;
    logic [OFS_W-1:0]  out_offset_reg;

    logic              fire;
    logic              produce;
    logic              in_range;
    logic              at_limit;
    logic [BYTE_W-1:0] win_s [DEPTH];
    logic [BYTE_W-1:0] cw [DEPTH];
    logic [DEPTH-1:0]  word_bit;
    logic              m0;
    logic              m1;
    logic              before0;
    logic              before1;
    logic [CMP_W-1:0]  n_ext;
    logic [CMP_W-1:0]  cnt0;
    logic [CMP_W-1:0]  len_ext;
    logic              c0_ok;
    logic              c1_ok;
    logic              hit;
    logic [CMP_W-1:0]  start;
    logic [EXT_W-1:0]  start_ext;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_valid && s_ready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            in_byte_reg <= s_byte;
            in_last_reg <= s_last;
        end
    end

    assign in_range = seen_reg < CNT_W'(MAX_TEXT);
    assign at_limit = seen_reg == CNT_W'(MAX_TEXT);

    // past the text limit the window freezes and is judged as it stands
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_win
        if (g == 0)
        begin : g_head
            assign win_s[g] = in_byte_reg;
        end
        else
        begin : g_tail
            assign win_s[g] = win_reg[g-1];
        end
        assign cw[g]       = in_range ? win_s[g] : win_reg[g];
        assign word_bit[g] = is_word_byte(cw[g]);
    end

    assign len_ext = CMP_W'(pattern_len);
    assign n_ext   = CMP_W'(seen_reg);
    assign cnt0    = in_range ? n_ext + CMP_W'(1) : n_ext;

    // alignment ending at the newest byte and alignment ending one byte earlier
    always_comb
    begin
        m0 = 1'b1;
        m1 = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (pattern_mask[i])
            begin
                if (fold_byte(cw[i], mode.case_sensitive) != pattern_aligned[i])
                    m0 = 1'b0;
                if (fold_byte(cw[i+1], mode.case_sensitive) != pattern_aligned[i])
                    m1 = 1'b0;
            end
        end
    end

    always_comb
    begin
        before0 = 1'b0;
        before1 = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CMP_W'(i) == len_ext && word_bit[i])
                before0 = 1'b1;
            if (CMP_W'(i) == len_ext + CMP_W'(1) && word_bit[i])
                before1 = 1'b1;
        end
    end

    assign c0_ok = (cnt0 >= len_ext) && m0 &&
                   !(mode.whole_word && (cnt0 > len_ext) && before0);
    assign c1_ok = (n_ext >= len_ext) && m1 &&
                   !((n_ext > len_ext) && before1) && !word_bit[0];

    always_comb
    begin
        hit   = 1'b0;
        start = cnt0 - len_ext;
        if (!reported_reg)
        begin
            if (in_range)
            begin
                if (!mode.whole_word)
                    hit = c0_ok;
                else if (c1_ok)
                begin
                    hit   = 1'b1;
                    start = n_ext - len_ext;
                end
                else if (in_last_reg && c0_ok)
                    hit = 1'b1;
            end
            else if (at_limit)
                hit = mode.whole_word && c0_ok;
        end
    end

    assign start_ext = EXT_W'(start);
    assign produce   = hit || (!reported_reg && in_last_reg);

    always_ff @(posedge clk)
    begin
        if (fire && !reported_reg && in_range)
            win_reg <= win_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (in_last_reg)
            begin
                seen_reg     <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                if (!reported_reg && (in_range || at_limit))
                    seen_reg <= seen_reg + CNT_W'(1);
                if (hit)
                    reported_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && produce)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
        begin
            out_found_reg  <= hit;
            out_offset_reg <= hit ? start_ext[OFS_W-1:0] : '0;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_found  = out_found_reg;
    assign m_offset = out_offset_reg;

    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CNT_W'(MAX_TEXT + 1))
        else $error("byte count ran past the text limit");

    a_hit_latched: assert property (@(posedge clk) disable iff (!rst_n)
        fire && hit && !in_last_reg |=> reported_reg)
        else $error("match not remembered");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |=> (seen_reg == '0) && !reported_reg)
        else $error("buffer state not cleared at last word");

    a_reported_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg |-> seen_reg != '0)
        else $error("match reported with empty buffer");

    a_miss_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_offset_reg == '0)
        else $error("nonzero offset on miss");

endmodule

`default_nettype wire

/* rtl/whole_word_pattern_search_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Streams one text buffer, one byte per word, and reports the offset of the
// first match of a 1 to MAX_PATTERN byte pattern, exact or ASCII case folded,
// optionally only where the match is bounded by non-word bytes or buffer
// edges. One byte is taken every cycle unless a result waits on m_axis_tready;
// the byte that decides a result passes an input register, a single compare
// of the shifted window against the pre-aligned pattern, and a result
// register. One result per buffer: found at the first match, or a miss at
// the last byte. In whole-word mode a match is confirmed one byte after its
// end or at the last byte. Bytes beyond MAX_TEXT are not searched; the first
// of them closes a pending whole-word match as a buffer end would. The mode
// bits take effect the cycle after a register write; pattern and length,
// with the pattern's case folding, pass a second, re-aligning register first.

module whole_word_pattern_search_unit #(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_TEXT    = 65536
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [wwps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wwps_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [wwps_pkg::BYTE_W-1:0]      s_axis_tdata,  // text_byte
    input  wire logic                             s_axis_tlast,  // last_byte
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [wwps_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // found, match_offset
);
    import wwps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    match_mode_t       mode;
    logic [LEN_W-1:0]  pattern_len;
    logic [BYTE_W-1:0] pattern_aligned [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pattern_mask;
    logic              m_found;
    logic [OFS_W-1:0]  m_offset;

    wwps_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .pattern_len     (pattern_len),
        .pattern_aligned (pattern_aligned),
        .pattern_mask    (pattern_mask)
    );

    wwps_engine #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_valid         (s_axis_tvalid),
        .s_ready         (s_axis_tready),
        .s_byte          (s_axis_tdata),
        .s_last          (s_axis_tlast),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .m_found         (m_found),
        .m_offset        (m_offset),
        .mode            (mode),
        .pattern_len     (pattern_len),
        .pattern_aligned (pattern_aligned),
        .pattern_mask    (pattern_mask)
    );

    assign m_axis_tdata = OUT_TDATA_W'({m_offset, m_found});

endmodule

`default_nettype wire
